// ===== src/qmmi_pkg.sv =====
// ----------------------------------------------------------------------------
// qmmi_pkg
// shared constants, types and arithmetic helpers for the quad motor mixer
// ----------------------------------------------------------------------------
package qmmi_pkg;

  localparam int GAIN_FRACTION_BITS = 16;
  localparam int INTEG_FRAC         = 16;
  localparam int GAIN_W             = 16;
  localparam int FIELD_W            = 12;
  localparam int PULSE_W            = 12;
  localparam int LIMIT_W            = 11;
  localparam int INTEG_W            = 28;
  localparam int DUTY_W             = 19;
  localparam int MIX_W              = 16;
  localparam int CFG_ADDR_W         = 3;
  localparam int CFG_DATA_W         = 16;

  // signed product of a zero-extended gain and a signed error
  localparam int PROD_W = GAIN_W + FIELD_W + 1;
  localparam int SHR    = (GAIN_FRACTION_BITS >= INTEG_FRAC) ?
                          (GAIN_FRACTION_BITS - INTEG_FRAC) : 0;
  localparam int SHL    = (GAIN_FRACTION_BITS < INTEG_FRAC) ?
                          (INTEG_FRAC - GAIN_FRACTION_BITS) : 0;
  localparam int INC_W  = PROD_W + SHL;
  localparam int SUM_W  = INC_W + 2;

  localparam int IN_DATA_W  = 10 * FIELD_W;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROLL_GAIN  = 3'd0,
    REG_PITCH_GAIN = 3'd1,
    REG_ARM_THRESH = 3'd2,
    REG_IDLE_THR   = 3'd3,
    REG_INT_LIMIT  = 3'd4,
    REG_MOTOR_MIN  = 3'd5,
    REG_MOTOR_MAX  = 3'd6
  } cfg_reg_t;

  // first stage payload: products already formed, other fields passed along
  typedef struct packed {
    logic                        run;
    logic [PULSE_W-1:0]          thr;
    logic signed [FIELD_W-1:0]   rs;
    logic signed [FIELD_W-1:0]   ps;
    logic signed [FIELD_W-1:0]   ys;
    logic signed [FIELD_W-1:0]   rc;
    logic signed [FIELD_W-1:0]   pc;
    logic signed [FIELD_W-1:0]   yc;
    logic signed [PROD_W-1:0]    rprod;
    logic signed [PROD_W-1:0]    pprod;
  } prod_stage_t;

  typedef struct packed {
    logic               active;
    logic [PULSE_W-1:0] left;
    logic [PULSE_W-1:0] front;
    logic [PULSE_W-1:0] right;
    logic [PULSE_W-1:0] back;
  } pulse_stage_t;

  // add the scaled increment, saturate at +/- limit in whole units
  function automatic logic signed [INTEG_W-1:0] integrate(
    input logic signed [INTEG_W-1:0] acc,
    input logic signed [PROD_W-1:0]  prod,
    input logic [LIMIT_W-1:0]        lim
  );
    logic signed [SUM_W-1:0] inc;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lim_s;
    logic signed [SUM_W-1:0] res;
    inc   = SUM_W'(prod);
    inc   = (GAIN_FRACTION_BITS >= INTEG_FRAC) ? (inc >>> SHR) : (inc <<< SHL);
    sum   = SUM_W'(acc) + inc;
    lim_s = $signed({{(SUM_W-LIMIT_W-INTEG_FRAC){1'b0}}, lim, {INTEG_FRAC{1'b0}}});
    res   = sum;
    if (sum < -lim_s) res = -lim_s;
    if (sum > lim_s)  res = lim_s;
    return INTEG_W'(res);
  endfunction

  // clamp to the motor range; low bound checked first
  function automatic logic [PULSE_W-1:0] clamp_pulse(
    input logic signed [MIX_W-1:0] m,
    input logic [PULSE_W-1:0]      lo,
    input logic [PULSE_W-1:0]      hi
  );
    logic signed [MIX_W-1:0] lo_s;
    logic signed [MIX_W-1:0] hi_s;
    lo_s = $signed(MIX_W'(lo));
    hi_s = $signed(MIX_W'(hi));
    if (m < lo_s)      return lo;
    else if (m > hi_s) return hi;
    else               return PULSE_W'(m);
  endfunction

  // pulse * 100 as shift-add
  function automatic logic [DUTY_W-1:0] to_duty(input logic [PULSE_W-1:0] p);
    logic [DUTY_W-1:0] pe;
    pe = DUTY_W'(p);
    return (pe << 6) + (pe << 5) + (pe << 2);
  endfunction

endpackage

// ===== src/quad_motor_mixer_integrator.sv =====
// ----------------------------------------------------------------------------
// quad_motor_mixer_integrator
// x-frame quadcopter motor mixer with roll and pitch integrators
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake           payload
//  in_      in   in_tvalid/tready    in_tdata  : ten 12-bit stick/pid/error fields
//  out_     out  out_tvalid/tready   out_tdata : four 19-bit duties, out_tuser: active
//  cfg_     in   cfg_we              cfg_addr register index, cfg_wdata value
//
//  three register stages: input (gain * error products), mix (integrators,
//  mix and clamp) and output (duty = pulse * 100); out_tvalid rises once a
//  word is in the output stage; one word can enter every cycle unless all
//  stages are full and out_tready is low; the integrators update as a word
//  moves from the input to the mix stage, so the next word always sees the
//  state left by the one before it; each stage advances when it is empty or
//  the stage after it moves, so a stalled output still lets the earlier
//  stages fill; rst_n (synchronous) empties the pipeline, zeroes the
//  integrators and loads the register defaults
//
module quad_motor_mixer_integrator
  import qmmi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // arm, throttle, roll_stick, pitch_stick, yaw_stick, roll_correction,
  // pitch_correction, yaw_correction, roll_err, pitch_err (12 bits each)
  input  logic [IN_DATA_W-1:0]    in_tdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // duty_left, duty_front, duty_right, duty_back (19 bits each), 4 zero bits
  output logic [OUT_DATA_W-1:0]   out_tdata,
  // active
  output logic                    out_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [GAIN_W-1:0]  roll_gain_r;
  logic [GAIN_W-1:0]  pitch_gain_r;
  logic [PULSE_W-1:0] arm_thresh_r;
  logic [PULSE_W-1:0] idle_thr_r;
  logic [LIMIT_W-1:0] int_limit_r;
  logic [PULSE_W-1:0] motor_min_r;
  logic [PULSE_W-1:0] motor_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_gain_r  <= '0;
      pitch_gain_r <= '0;
      arm_thresh_r <= PULSE_W'(1500);
      idle_thr_r   <= PULSE_W'(1050);
      int_limit_r  <= LIMIT_W'(100);
      motor_min_r  <= PULSE_W'(1000);
      motor_max_r  <= PULSE_W'(2000);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROLL_GAIN:  roll_gain_r  <= cfg_wdata;
        REG_PITCH_GAIN: pitch_gain_r <= cfg_wdata;
        REG_ARM_THRESH: arm_thresh_r <= cfg_wdata[PULSE_W-1:0];
        REG_IDLE_THR:   idle_thr_r   <= cfg_wdata[PULSE_W-1:0];
        REG_INT_LIMIT:  int_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        REG_MOTOR_MIN:  motor_min_r  <= cfg_wdata[PULSE_W-1:0];
        REG_MOTOR_MAX:  motor_max_r  <= cfg_wdata[PULSE_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // pipeline valids and per-stage advance
  logic         s1_vld_r, s2_vld_r, s3_vld_r;
  logic         s3_rdy, s2_rdy, s1_rdy;
  prod_stage_t  s1_r, s1_nxt;
  pulse_stage_t s2_r, s2_nxt;
  logic [OUT_DATA_W-1:0] s3_data_r, s3_data_nxt;
  logic         s3_active_r;

  logic signed [INTEG_W-1:0] roll_int_r, pitch_int_r;
  logic signed [INTEG_W-1:0] roll_int_nxt, pitch_int_nxt;

  assign s3_rdy    = !s3_vld_r || out_tready;
  assign s2_rdy    = !s2_vld_r || s3_rdy;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_tready = s1_rdy;

  // input stage: unpack, form products, decide arm state
  logic [PULSE_W-1:0]        in_arm, in_thr;
  logic signed [FIELD_W-1:0] in_re, in_pe;

  always_comb begin
    in_arm       = in_tdata[0*FIELD_W +: FIELD_W];
    in_thr       = in_tdata[1*FIELD_W +: FIELD_W];
    in_re        = $signed(in_tdata[8*FIELD_W +: FIELD_W]);
    in_pe        = $signed(in_tdata[9*FIELD_W +: FIELD_W]);
    s1_nxt.run   = (in_arm > arm_thresh_r) && (in_thr > idle_thr_r);
    s1_nxt.thr   = in_thr;
    s1_nxt.rs    = $signed(in_tdata[2*FIELD_W +: FIELD_W]);
    s1_nxt.ps    = $signed(in_tdata[3*FIELD_W +: FIELD_W]);
    s1_nxt.ys    = $signed(in_tdata[4*FIELD_W +: FIELD_W]);
    s1_nxt.rc    = $signed(in_tdata[5*FIELD_W +: FIELD_W]);
    s1_nxt.pc    = $signed(in_tdata[6*FIELD_W +: FIELD_W]);
    s1_nxt.yc    = $signed(in_tdata[7*FIELD_W +: FIELD_W]);
    s1_nxt.rprod = PROD_W'($signed({1'b0, roll_gain_r})) * PROD_W'(in_re);
    s1_nxt.pprod = PROD_W'($signed({1'b0, pitch_gain_r})) * PROD_W'(in_pe);
  end

  // mix stage: integrate, take floor, mix four motors, clamp
  logic signed [FIELD_W-1:0] lr, lp;
  logic signed [MIX_W-1:0]   thr_s, rs_s, ps_s, ys_s, rc_s, pc_s, yc_s, lr_s, lp_s;
  logic signed [MIX_W-1:0]   mix_left, mix_front, mix_right, mix_back;

  always_comb begin
    if (s1_r.run) begin
      roll_int_nxt  = integrate(roll_int_r, s1_r.rprod, int_limit_r);
      pitch_int_nxt = integrate(pitch_int_r, s1_r.pprod, int_limit_r);
    end else begin
      roll_int_nxt  = '0;
      pitch_int_nxt = '0;
    end
    // floor of a q.16 value is its upper bits; limit keeps it within 12 bits
    lr    = roll_int_nxt[INTEG_W-1:INTEG_FRAC];
    lp    = pitch_int_nxt[INTEG_W-1:INTEG_FRAC];
    thr_s = $signed(MIX_W'(s1_r.thr));
    rs_s  = MIX_W'(s1_r.rs);
    ps_s  = MIX_W'(s1_r.ps);
    ys_s  = MIX_W'(s1_r.ys);
    rc_s  = MIX_W'(s1_r.rc);
    pc_s  = MIX_W'(s1_r.pc);
    yc_s  = MIX_W'(s1_r.yc);
    lr_s  = MIX_W'(lr);
    lp_s  = MIX_W'(lp);
    mix_left  = thr_s - rc_s + rs_s - lr_s + ys_s - yc_s;
    mix_front = thr_s + pc_s - ps_s + lp_s - ys_s + yc_s;
    mix_right = thr_s + rc_s - rs_s + lr_s + ys_s - yc_s;
    mix_back  = thr_s - pc_s + ps_s - lp_s - ys_s + yc_s;
    if (s1_r.run) begin
      s2_nxt.active = 1'b1;
      s2_nxt.left   = clamp_pulse(mix_left,  motor_min_r, motor_max_r);
      s2_nxt.front  = clamp_pulse(mix_front, motor_min_r, motor_max_r);
      s2_nxt.right  = clamp_pulse(mix_right, motor_min_r, motor_max_r);
      s2_nxt.back   = clamp_pulse(mix_back,  motor_min_r, motor_max_r);
    end else begin
      // disarmed or at idle: every motor at the minimum
      s2_nxt.active = 1'b0;
      s2_nxt.left   = motor_min_r;
      s2_nxt.front  = motor_min_r;
      s2_nxt.right  = motor_min_r;
      s2_nxt.back   = motor_min_r;
    end
  end

  // output stage: scale to hundredths of a microsecond
  always_comb begin
    s3_data_nxt = {{(OUT_DATA_W-4*DUTY_W){1'b0}},
                   to_duty(s2_r.back), to_duty(s2_r.right),
                   to_duty(s2_r.front), to_duty(s2_r.left)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      roll_int_r  <= '0;
      pitch_int_r <= '0;
    end else begin
      if (s1_rdy) begin
        s1_vld_r <= in_tvalid;
      end
      if (s2_rdy) begin
        s2_vld_r <= s1_vld_r;
        // state moves with the word leaving the input stage
        if (s1_vld_r) begin
          roll_int_r  <= roll_int_nxt;
          pitch_int_r <= pitch_int_nxt;
        end
      end
      if (s3_rdy) begin
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s1_rdy && in_tvalid) begin
      s1_r <= s1_nxt;
    end
    if (s2_rdy && s1_vld_r) begin
      s2_r <= s2_nxt;
    end
    if (s3_rdy && s2_vld_r) begin
      s3_data_r   <= s3_data_nxt;
      s3_active_r <= s2_r.active;
    end
  end

  assign out_tvalid = s3_vld_r;
  assign out_tdata  = s3_data_r;
  assign out_tuser  = s3_active_r;

endmodule
